[design/chm_pkg.sv]
// Shared types, widths and operation codes of the chained hash map.
package chm_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ActW        = 2;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned ValW        = 32;
  localparam int unsigned CountW      = 5;

  // Operation codes; the unused code behaves as a search
  localparam logic [ActW-1:0] ActSearch = 2'd0;
  localparam logic [ActW-1:0] ActInsert = 2'd1;
  localparam logic [ActW-1:0] ActRemove = 2'd2;

  typedef struct packed {
    logic [ActW-1:0]        action;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } item_t;

  typedef struct packed {
    logic                   found;
    logic signed [ValW-1:0] old_value;
    logic                   table_full;
    logic [CountW-1:0]      entry_count;
  } result_t;

endpackage

[design/chm_if.sv]
// Valid/ready channel interfaces for the operation and result transactions.
interface chm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [chm_pkg::ActW-1:0]               action;
  logic signed [chm_pkg::KeyW-1:0]        key;
  logic signed [chm_pkg::ValW-1:0]        value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface chm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   found;
  logic signed [chm_pkg::ValW-1:0]        old_value;
  logic                                   table_full;
  logic [chm_pkg::CountW-1:0]             entry_count;

  modport source (output valid, output found, output old_value, output table_full,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input old_value, input table_full,
                  input entry_count, output ready);
endinterface

[design/chm_mod.sv]
// Bucket unit: key magnitude modulo the capacity by reciprocal multiplication.
module chm_mod #(
  parameter int unsigned CAPACITY = chm_pkg::DefCapacity,
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chm_pkg::KeyW-1:0]    key_i,
  output logic                        done_o,
  output logic [AW-1:0]               bucket_o
);

  localparam int unsigned RW    = AW + 1;
  localparam int unsigned KW    = chm_pkg::KeyW;
  localparam int unsigned ProdW = 2 * chm_pkg::KeyW;
  // floor(2^32 / CAPACITY): the quotient estimate is low by at most one
  localparam logic [ProdW-1:0] Scale  = ProdW'(1) << KW;
  localparam logic [KW-1:0]    RecipM = KW'(Scale / ProdW'(CAPACITY));
  localparam logic [RW-1:0]    CapR   = RW'(CAPACITY);

  localparam int unsigned PW = 2;
  localparam logic [PW-1:0] PH_MUL = 2'd0;
  localparam logic [PW-1:0] PH_SUB = 2'd1;
  localparam logic [PW-1:0] PH_FIX = 2'd2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [PW-1:0]     phase_q, phase_d;
  logic [KW-1:0]     mag_q, mag_d;
  logic [KW-1:0]     quo_q, quo_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [KW-1:0]     mag_in;
  logic [ProdW-1:0]  prod;
  logic [RW-1:0]     qc_lo;

  // Take the magnitude; the most negative key maps to 2^31
  assign mag_in = key_i[KW-1] ? (-key_i) : key_i;
  assign prod   = ProdW'(mag_q) * ProdW'(RecipM);
  assign qc_lo  = quo_q[RW-1:0] * CapR;

  // Estimate the quotient, subtract its multiple, then correct once
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    mag_d   = mag_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = PH_MUL;
      mag_d   = mag_in;
    end else if (busy_q) begin
      case (phase_q)
        PH_MUL: begin
          quo_d   = prod[ProdW-1:KW];
          phase_d = PH_SUB;
        end
        PH_SUB: begin
          // The difference is below twice the capacity, so low bits suffice
          rem_d   = mag_q[RW-1:0] - qc_lo;
          phase_d = PH_FIX;
        end
        PH_FIX: begin
          rem_d  = (rem_q >= CapR) ? (rem_q - CapR) : rem_q;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_MUL;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[AW-1:0];

endmodule

[design/chm_engine.sv]
// Sequencer with the bucket, key, value and link memories: walk, insert, remove.
module chm_engine #(
  parameter int unsigned CAPACITY = chm_pkg::DefCapacity
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  chm_pkg::item_t   item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output chm_pkg::result_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NoneIdx = IW'(CAPACITY);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  localparam int unsigned SW = 4;
  localparam logic [SW-1:0] S_CLEAR  = 4'd0;
  localparam logic [SW-1:0] S_IDLE   = 4'd1;
  localparam logic [SW-1:0] S_HASH   = 4'd2;
  localparam logic [SW-1:0] S_HEAD   = 4'd3;
  localparam logic [SW-1:0] S_CHECK  = 4'd4;
  localparam logic [SW-1:0] S_CMP    = 4'd5;
  localparam logic [SW-1:0] S_ACT    = 4'd6;
  localparam logic [SW-1:0] S_INS_WR = 4'd7;
  localparam logic [SW-1:0] S_UNLINK = 4'd8;
  localparam logic [SW-1:0] S_FREE   = 4'd9;
  localparam logic [SW-1:0] S_DONE   = 4'd10;

  // Control state
  logic [SW-1:0] state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [IW-1:0] free_q, free_d;
  logic [IW-1:0] count_q, count_d;

  // Item and walk payload
  logic [chm_pkg::ActW-1:0] act_q, act_d;
  logic [chm_pkg::KeyW-1:0] key_q, key_d;
  logic [chm_pkg::ValW-1:0] val_q, val_d;
  logic [AW-1:0]            bkt_q, bkt_d;
  logic [IW-1:0]            cur_q, cur_d;
  logic [IW-1:0]            prev_q, prev_d;
  logic [IW-1:0]            head_q, head_d;
  logic [IW-1:0]            next_q, next_d;
  logic [IW-1:0]            steps_q, steps_d;
  logic                     found_q, found_d;
  logic                     full_q, full_d;
  logic [chm_pkg::ValW-1:0] old_q, old_d;

  // Memories and their ports
  logic [IW-1:0]            head_mem [CAPACITY];
  logic [chm_pkg::KeyW-1:0] key_mem  [CAPACITY];
  logic [chm_pkg::ValW-1:0] val_mem  [CAPACITY];
  logic [IW-1:0]            link_mem [CAPACITY];

  logic [AW-1:0]            head_ra, head_wa, node_ra, link_wa, node_wa;
  logic                     head_we, link_we, key_we, val_we;
  logic [IW-1:0]            head_wd, link_wd;
  logic [chm_pkg::ValW-1:0] val_wd;
  logic [IW-1:0]            head_rd_q, link_rd_q;
  logic [chm_pkg::KeyW-1:0] key_rd_q;
  logic [chm_pkg::ValW-1:0] val_rd_q;

  // Bucket unit
  logic          mod_start, mod_done;
  logic [AW-1:0] mod_bucket;

  chm_mod #(.CAPACITY(CAPACITY)) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .key_i    (item_i.key),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  // Sequence one transaction through hash, walk and update
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    free_d    = free_q;
    count_d   = count_q;
    act_d     = act_q;
    key_d     = key_q;
    val_d     = val_q;
    bkt_d     = bkt_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    head_d    = head_q;
    next_d    = next_q;
    steps_d   = steps_q;
    found_d   = found_q;
    full_d    = full_q;
    old_d     = old_q;
    mod_start = 1'b0;
    head_ra   = mod_bucket;
    node_ra   = cur_q[AW-1:0];
    head_we   = 1'b0;
    head_wa   = bkt_q;
    head_wd   = NoneIdx;
    link_we   = 1'b0;
    link_wa   = cur_q[AW-1:0];
    link_wd   = free_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    node_wa   = cur_q[AW-1:0];
    val_wd    = val_q;
    case (state_q)
      S_CLEAR: begin
        // Empty every bucket and chain the free list in order
        head_we = 1'b1;
        head_wa = idx_q;
        head_wd = NoneIdx;
        link_we = 1'b1;
        link_wa = idx_q;
        link_wd = IW'(idx_q) + 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = item_i.action;
          key_d     = item_i.key;
          val_d     = item_i.value;
          found_d   = 1'b0;
          full_d    = 1'b0;
          old_d     = '0;
          mod_start = 1'b1;
          state_d   = S_HASH;
        end
      end
      S_HASH: begin
        // The head read is issued with the final remainder
        if (mod_done) begin
          bkt_d   = mod_bucket;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cur_d   = head_rd_q;
        head_d  = head_rd_q;
        prev_d  = NoneIdx;
        steps_d = '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // Stop at the end of the chain or after a full table's worth of nodes
        if (cur_q < NoneIdx && steps_q < NoneIdx) begin
          state_d = S_CMP;
        end else begin
          state_d = S_ACT;
        end
      end
      S_CMP: begin
        if (key_rd_q == key_q) begin
          found_d = 1'b1;
          old_d   = val_rd_q;
          next_d  = link_rd_q;
          state_d = S_ACT;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd_q;
          steps_d = steps_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      S_ACT: begin
        case (act_q)
          chm_pkg::ActInsert: begin
            if (found_q) begin
              val_we  = 1'b1;
              state_d = S_DONE;
            end else if (count_q >= NoneIdx || free_q >= NoneIdx) begin
              full_d  = 1'b1;
              state_d = S_DONE;
            end else begin
              // Fetch the successor of the free-list head
              node_ra = free_q[AW-1:0];
              state_d = S_INS_WR;
            end
          end
          chm_pkg::ActRemove: begin
            state_d = found_q ? S_UNLINK : S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_INS_WR: begin
        // Fill the new node and link it in at the head of its bucket
        node_wa = free_q[AW-1:0];
        key_we  = 1'b1;
        val_we  = 1'b1;
        link_we = 1'b1;
        link_wa = free_q[AW-1:0];
        link_wd = head_q;
        head_we = 1'b1;
        head_wd = free_q;
        free_d  = link_rd_q;
        count_d = count_q + 1'b1;
        state_d = S_DONE;
      end
      S_UNLINK: begin
        if (prev_q < NoneIdx) begin
          link_we = 1'b1;
          link_wa = prev_q[AW-1:0];
          link_wd = next_q;
        end else begin
          head_we = 1'b1;
          head_wd = next_q;
        end
        state_d = S_FREE;
      end
      S_FREE: begin
        // Push the removed node onto the free list
        link_we = 1'b1;
        free_d  = cur_q;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      free_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      free_q  <= free_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    val_q   <= val_d;
    bkt_q   <= bkt_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    head_q  <= head_d;
    next_q  <= next_d;
    steps_q <= steps_d;
    found_q <= found_d;
    full_q  <= full_d;
    old_q   <= old_d;
  end

  // Bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_q <= head_mem[head_ra];
  end

  // Node memories
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[node_wa] <= key_q;
    end
    key_rd_q <= key_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[node_wa] <= val_wd;
    end
    val_rd_q <= val_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[node_ra];
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.found       = found_q;
  assign res_o.old_value   = old_q;
  assign res_o.table_full  = full_q;
  assign res_o.entry_count = chm_pkg::CountW'(count_q);

`ifndef SYNTHESIS
  a_free_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |-> ((count_q == NoneIdx) == (free_q >= NoneIdx)))
    else $error("free list state disagrees with entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= NoneIdx) && (state_q == S_CLEAR || steps_q <= NoneIdx || state_q == S_IDLE
      || state_q == S_HASH || state_q == S_HEAD || state_q == S_DONE))
    else $error("entry count or walk length out of range");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.table_full) |-> (!res_o.found && res_o.old_value == '0))
    else $error("rejected insert reports a found key");

  a_accept_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_HASH))
    else $error("accepted transaction did not start the bucket unit");
`endif

endmodule

[design/chained_hash_map.sv]
// Top level of the chained hash map: channel ports and the result register.
//
// Use: each transaction on in_i carries an action (search, insert/update,
// remove), a signed key and a value. Each gives exactly one transaction on
// out_o: whether the key was present, its old value (zero if absent), a
// full flag for a rejected insert, and the stored entry count afterwards.
// Flow: the bucket (key magnitude modulo CAPACITY) comes from a
// reciprocal-multiply remainder unit (multiply, subtract, correct); the
// bucket chain is then walked node by node through the registered memory
// reads, and the update follows. The result shows on out_o as in_i.ready
// rises again, so an item is not accepted before the previous one is
// through; in_i.ready is high only between items.
// Reset: a clearing pass empties the buckets and chains the free list;
// in_i.ready stays low meanwhile.
// Stall: the result waits in an output register; the next item is accepted
// and processed meanwhile, and holds in its last step until the register
// frees.
module chained_hash_map #(
  parameter int unsigned CAPACITY = chm_pkg::DefCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chm_in_if.sink     in_i,
  chm_out_if.source  out_o
);

  chm_pkg::item_t   item;
  chm_pkg::result_t res, res_q;
  logic             res_valid, res_ready;
  logic             eng_ready;
  logic             out_valid_q, out_valid_d;

  assign item.action = in_i.action;
  assign item.key    = in_i.key;
  assign item.value  = in_i.value;
  assign in_i.ready  = eng_ready;

  chm_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (eng_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Load the result register when empty or draining this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = res_q.found;
  assign out_o.old_value   = res_q.old_value;
  assign out_o.table_full  = res_q.table_full;
  assign out_o.entry_count = res_q.entry_count;

endmodule

[bench/chained_hash_map_test.sv]
// Self-checking testbench of the chained hash map: directed, full-table, stall and random traffic.
`timescale 1ns / 1ps

module chained_hash_map_test;

  localparam int unsigned Cap        = chm_pkg::DefCapacity;
  localparam int unsigned NoNode     = Cap;
  localparam int          StallLimit = 3000;
  localparam int          TailCycles = 2 * Cap + 80;
  localparam int          LongHold   = 300;

  // The spare operation code behaves as a search
  localparam logic [chm_pkg::ActW-1:0] ActUnused = 2'd3;

  localparam logic signed [chm_pkg::KeyW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [chm_pkg::KeyW-1:0] KeyMax = 32'sh7FFF_FFFF;
  localparam logic signed [chm_pkg::ValW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [chm_pkg::ValW-1:0] ValMax = 32'sh7FFF_FFFF;

  logic clk_i;
  logic rst_ni;

  chm_in_if  in_if ();
  chm_out_if out_if ();

  chained_hash_map dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the map: chain heads, node store, free list and count
  int unsigned                      shadow_head [Cap];
  int unsigned                      shadow_next [Cap];
  logic signed [chm_pkg::KeyW-1:0]  shadow_key  [Cap];
  logic signed [chm_pkg::ValW-1:0]  shadow_val  [Cap];
  int unsigned                      free_node;
  int unsigned                      shadow_count;

  chm_pkg::result_t replies_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int mismatches;

  int n_search, n_insert, n_remove, n_unused, n_hits, n_rejected, longest_walk;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow map and return the reply it must produce
  function automatic chm_pkg::result_t apply_to_shadow_map(chm_pkg::item_t op);
    chm_pkg::result_t rsp;
    logic [31:0]      mag;
    int unsigned      bkt, prev, cur, walked, slot;
    logic             hit;
    rsp    = '0;
    hit    = 1'b0;
    mag    = op.key[chm_pkg::KeyW-1] ? (32'd0 - unsigned'(op.key)) : unsigned'(op.key);
    bkt    = mag % Cap;
    prev   = NoNode;
    cur    = shadow_head[bkt];
    walked = 0;
    // Walk the bucket chain, bounded by the table size
    while (!hit && cur < Cap && walked < Cap) begin
      if (shadow_key[cur] == op.key) begin
        hit = 1'b1;
      end else begin
        prev = cur;
        cur  = shadow_next[cur];
        walked++;
      end
    end
    if (walked > longest_walk) longest_walk = walked;
    rsp.found = hit;
    if (hit) rsp.old_value = shadow_val[cur];

    if (op.action == chm_pkg::ActInsert) begin
      if (hit) begin
        shadow_val[cur] = op.value;
      end else if (shadow_count >= Cap || free_node >= Cap) begin
        rsp.table_full = 1'b1;
      end else begin
        // Take the free-list head and link it in front of the chain
        slot              = free_node;
        free_node         = shadow_next[slot];
        shadow_key[slot]  = op.key;
        shadow_val[slot]  = op.value;
        shadow_next[slot] = shadow_head[bkt];
        shadow_head[bkt]  = slot;
        shadow_count++;
      end
    end else if (op.action == chm_pkg::ActRemove && hit) begin
      // Unlink the node and push it onto the free list
      if (prev < Cap) shadow_next[prev] = shadow_next[cur];
      else            shadow_head[bkt]  = shadow_next[cur];
      shadow_next[cur] = free_node;
      free_node        = cur;
      if (shadow_count > 0) shadow_count--;
    end
    rsp.entry_count = shadow_count[chm_pkg::CountW-1:0];
    return rsp;
  endfunction

  // Keys clustered in a few buckets so that chains grow long and lookups hit
  function automatic logic signed [chm_pkg::KeyW-1:0] pick_key();
    int                              r;
    int unsigned                     mag;
    logic signed [chm_pkg::KeyW-1:0] k;
    r = $urandom_range(99);
    if (r < 8) begin
      k = $urandom;
    end else if (r < 12) begin
      case ($urandom_range(3))
        0:       k = KeyMin;
        1:       k = KeyMax;
        2:       k = '0;
        default: k = -1;
      endcase
    end else begin
      if ($urandom_range(99) < 70) mag = $urandom_range(2);
      else                         mag = $urandom_range(Cap - 1);
      mag = mag + Cap * $urandom_range(5);
      k   = mag;
      if ($urandom_range(1) != 0) k = -k;
    end
    return k;
  endfunction

  // Offer one operation until accepted, record its reply, then maybe idle
  task automatic issue_op(input logic [chm_pkg::ActW-1:0] act,
                          input logic signed [chm_pkg::KeyW-1:0] k,
                          input logic signed [chm_pkg::ValW-1:0] v);
    chm_pkg::item_t   op;
    chm_pkg::result_t rsp;
    op.action = act;
    op.key    = k;
    op.value  = v;
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.key    <= k;
    in_if.value  <= v;
    do @(posedge clk_i); while (!in_if.ready);
    rsp = apply_to_shadow_map(op);
    replies_due.push_back(rsp);
    case (act)
      chm_pkg::ActSearch: n_search++;
      chm_pkg::ActInsert: n_insert++;
      chm_pkg::ActRemove: n_remove++;
      default:            n_unused++;
    endcase
    if (rsp.found)      n_hits++;
    if (rsp.table_full) n_rejected++;
    // Idle the sender for a random stretch
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Hold the sender until every outstanding reply has come back
  task automatic wait_for_all_replies();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  // Extremes of keys and values, every operation, chain head and tail removal
  task automatic test_directed();
    issue_op(chm_pkg::ActSearch, 0, 0);
    issue_op(chm_pkg::ActRemove, 7, ValMax);
    issue_op(chm_pkg::ActInsert, 0, ValMax);
    issue_op(chm_pkg::ActInsert, KeyMax, ValMin);
    issue_op(chm_pkg::ActInsert, KeyMin, 1);
    issue_op(chm_pkg::ActInsert, 16, -1);
    issue_op(chm_pkg::ActInsert, -16, 5);
    issue_op(chm_pkg::ActSearch, KeyMin, 0);
    issue_op(chm_pkg::ActSearch, 32, 0);
    issue_op(chm_pkg::ActInsert, 16, 123);
    issue_op(ActUnused, 16, ValMax);
    issue_op(chm_pkg::ActRemove, 0, 0);
    issue_op(chm_pkg::ActRemove, -16, 0);
    issue_op(chm_pkg::ActRemove, KeyMin, 0);
    issue_op(chm_pkg::ActSearch, 0, 0);
    issue_op(chm_pkg::ActInsert, 0, 32'sh5555_5555);
    issue_op(chm_pkg::ActInsert, -1, 32'shAAAA_AAAA);
    issue_op(chm_pkg::ActInsert, 1, 0);
    issue_op(chm_pkg::ActSearch, -1, 0);
    issue_op(chm_pkg::ActRemove, 1, 0);
    issue_op(chm_pkg::ActRemove, -1, 0);
    issue_op(chm_pkg::ActRemove, 16, 0);
    issue_op(chm_pkg::ActRemove, KeyMax, 0);
    issue_op(chm_pkg::ActRemove, 0, 0);
    wait_for_all_replies();
  endtask

  // Fill every node, reject a new key, update while full, then empty in random order
  task automatic test_full_table();
    logic signed [chm_pkg::KeyW-1:0] fill_key [Cap];
    logic signed [chm_pkg::KeyW-1:0] swap;
    int                              j;
    for (int i = 0; i < Cap; i++) begin
      fill_key[i] = (i % 3) + Cap * (i / 3 + 1);
      if (i % 2 != 0) fill_key[i] = -fill_key[i];
      issue_op(chm_pkg::ActInsert, fill_key[i], $urandom);
    end
    issue_op(chm_pkg::ActInsert, 3, ValMax);
    issue_op(chm_pkg::ActInsert, fill_key[7], ValMin);
    issue_op(chm_pkg::ActSearch, fill_key[0], 0);
    issue_op(chm_pkg::ActSearch, 3, 0);
    // Shuffle the removal order so that nodes leave from every chain position
    for (int i = Cap - 1; i > 0; i--) begin
      j           = $urandom_range(i);
      swap        = fill_key[i];
      fill_key[i] = fill_key[j];
      fill_key[j] = swap;
    end
    for (int i = 0; i < Cap; i++) issue_op(chm_pkg::ActRemove, fill_key[i], 0);
    issue_op(chm_pkg::ActRemove, fill_key[0], 0);
    wait_for_all_replies();
  endtask

  // Hold off the receiver for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    send_idle_pct    = 0;
    recv_hold_cycles = LongHold;
    repeat (12) issue_op(chm_pkg::ActInsert, pick_key(), $urandom);
    wait_for_all_replies();
  endtask

  // Random mix, insert share steered by how full the table is
  task automatic test_random_traffic(input int n_items, input int sender_pct,
                                     input int receiver_pct);
    logic [chm_pkg::ActW-1:0] act;
    int                       r;
    int                       ins_share;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (n_items) begin
      if (shadow_count < 4)       ins_share = 50;
      else if (shadow_count > 12) ins_share = 28;
      else                        ins_share = 36;
      r = $urandom_range(99);
      if (r < 5)                   act = ActUnused;
      else if (r < 27)             act = chm_pkg::ActSearch;
      else if (r < 27 + ins_share) act = chm_pkg::ActInsert;
      else                         act = chm_pkg::ActRemove;
      issue_op(act, pick_key(), $urandom);
    end
    wait_for_all_replies();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each reply transaction against the oldest outstanding prediction
  initial begin
    chm_pkg::result_t want;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got found %0b old %0h full %0b count %0d",
                   $time, out_if.found, out_if.old_value, out_if.table_full,
                   out_if.entry_count);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          report_field("found", want.found, out_if.found);
          report_field("old_value", want.old_value, out_if.old_value);
          report_field("table_full", want.table_full, out_if.table_full);
          report_field("entry_count", want.entry_count, out_if.entry_count);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d replies outstanding",
                 $time, quiet, replies_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.action     <= chm_pkg::ActSearch;
    in_if.key        <= '0;
    in_if.value      <= '0;
    send_idle_pct    = 22;
    recv_idle_pct    = 76;
    recv_hold_cycles = 0;
    mismatches       = 0;
    n_search = 0; n_insert = 0; n_remove = 0; n_unused = 0;
    n_hits = 0; n_rejected = 0; longest_walk = 0;
    // Empty buckets, free list chained in index order
    for (int i = 0; i < Cap; i++) begin
      shadow_head[i] = NoNode;
      shadow_next[i] = (i + 1 < Cap) ? i + 1 : NoNode;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
    end
    free_node    = 0;
    shadow_count = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_table();
    test_output_backpressure();
    test_random_traffic(560, 22, 76);
    test_random_traffic(560, 76, 22);
    test_random_traffic(560, 0, 0);

    repeat (TailCycles) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d replies never arrived, expected found %0b old %0h",
               $time, replies_due.size(), replies_due[0].found, replies_due[0].old_value);
      mismatches++;
    end

    $display("Covered %0d operations: %0d searches, %0d inserts, %0d removes, %0d spare-code",
             n_search + n_insert + n_remove + n_unused, n_search, n_insert, n_remove, n_unused);
    $display("Key hits %0d, full-table rejects %0d, longest chain walk %0d, mismatches %0d",
             n_hits, n_rejected, longest_walk, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[chained_hash_map.f]
design/chm_pkg.sv
design/chm_if.sv
design/chm_mod.sv
design/chm_engine.sv
design/chained_hash_map.sv
bench/chained_hash_map_test.sv
